/* rtl/rmh_pkg.sv */
// Shared constants and types for the running median block.
`timescale 1ns / 1ps

package rmh_pkg;

   localparam int HEAP_DEPTH_DEF  = 1024;
   localparam int SAMPLE_BITS_DEF = 32;

   localparam int REQ_DATA_BITS = 32;
   localparam int MEDIAN_BITS   = 33;
   localparam int COUNT_BITS    = 12;
   localparam int RSP_DATA_BITS = 48;

   localparam logic HEAP_LOWER = 1'b0;
   localparam logic HEAP_UPPER = 1'b1;

   // One heap operation as handed to the heap engine.
   typedef struct packed {
      logic pop;
      logic hsel;
   } rmh_cmd_type;

   // One planned step of an item: the operation and where its value comes from.
   typedef struct packed {
      logic vld;
      logic pop;
      logic hsel;
      logic use_pop;
   } rmh_op_type;

endpackage

/* rtl/rmh_ram.sv */
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module rmh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic                     we,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/rmh_heap_engine.sv */
// Heap engine: both heap memories and one compare unit that sifts entries up or down.
`timescale 1ns / 1ps

module rmh_heap_engine
   import rmh_pkg::*;
#(
   parameter int HEAP_DEPTH  = HEAP_DEPTH_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  rmh_cmd_type                            cmd,
   input  logic signed [SAMPLE_BITS-1:0]          start_value,
   output logic                                   done,
   output logic signed [SAMPLE_BITS-1:0]          pop_value,
   output logic signed [SAMPLE_BITS-1:0]          top_lower,
   output logic signed [SAMPLE_BITS-1:0]          top_upper,
   output logic [$clog2(HEAP_DEPTH+1)-1:0]        count_lower,
   output logic [$clog2(HEAP_DEPTH+1)-1:0]        count_upper
);

   localparam int IW = $clog2(HEAP_DEPTH);
   localparam int CW = $clog2(HEAP_DEPTH + 1);
   localparam int WW = IW + 2;

   typedef enum logic [9:0] {
      E_IDLE    = 10'b00_0000_0001,
      E_UP_RD   = 10'b00_0000_0010,
      E_UP_CMP  = 10'b00_0000_0100,
      E_DN_LAST = 10'b00_0000_1000,
      E_DN_CHK  = 10'b00_0001_0000,
      E_DN_L    = 10'b00_0010_0000,
      E_DN_R    = 10'b00_0100_0000,
      E_DN_SEL  = 10'b00_1000_0000,
      E_WR      = 10'b01_0000_0000,
      E_FIN     = 10'b10_0000_0000
   } eng_state_type;

   eng_state_type state_ff, state_in;
   logic          hsel_ff, hsel_in;
   logic          pop_ff, pop_in;
   logic [IW-1:0] i_ff, i_in;
   logic [IW-1:0] bidx_ff, bidx_in;
   logic [CW-1:0] m_ff, m_in;
   logic [CW-1:0] cnt_ff [2];
   logic [CW-1:0] cnt_in [2];
   logic signed [SAMPLE_BITS-1:0] v_ff, v_in;
   logic signed [SAMPLE_BITS-1:0] best_ff, best_in;
   logic signed [SAMPLE_BITS-1:0] root_ff, root_in;
   logic signed [SAMPLE_BITS-1:0] top_ff [2];
   logic signed [SAMPLE_BITS-1:0] top_in [2];

   logic [IW-1:0]          ram_addr;
   logic                   ram_we;
   logic [SAMPLE_BITS-1:0] ram_wdata;
   logic [SAMPLE_BITS-1:0] rd_lower, rd_upper;
   logic signed [SAMPLE_BITS-1:0] rdata;

   logic signed [SAMPLE_BITS-1:0] cmp_a, cmp_b;
   logic                          above;

   logic [IW-1:0] parent;
   logic [WW-1:0] l_w, r_w, m_w;
   logic          l_ok, r_ok;
   logic [CW-1:0] cnt_sel;
   logic [CW-1:0] cnt_dec;

   rmh_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(HEAP_DEPTH)) u_lower_ram (
      .clock (clock),
      .addr  (ram_addr),
      .we    (ram_we && (hsel_ff == HEAP_LOWER)),
      .wdata (ram_wdata),
      .rdata (rd_lower)
   );

   rmh_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(HEAP_DEPTH)) u_upper_ram (
      .clock (clock),
      .addr  (ram_addr),
      .we    (ram_we && (hsel_ff == HEAP_UPPER)),
      .wdata (ram_wdata),
      .rdata (rd_upper)
   );

   assign rdata = (hsel_ff == HEAP_UPPER) ? $signed(rd_upper) : $signed(rd_lower);

   // The single compare unit: max-heap order for the lower heap, min-heap order for the upper.
   assign above = (hsel_ff == HEAP_LOWER) ? (cmp_a > cmp_b) : (cmp_a < cmp_b);

   assign parent  = (i_ff - IW'(1)) >> 1;
   assign l_w     = {1'b0, i_ff, 1'b1};
   assign r_w     = l_w + WW'(1);
   assign m_w     = WW'(m_ff);
   assign l_ok    = l_w < m_w;
   assign r_ok    = r_w < m_w;
   assign cnt_sel = cnt_ff[cmd.hsel];
   assign cnt_dec = cnt_sel - CW'(1);

   always_comb begin
      state_in  = state_ff;
      hsel_in   = hsel_ff;
      pop_in    = pop_ff;
      i_in      = i_ff;
      bidx_in   = bidx_ff;
      m_in      = m_ff;
      cnt_in    = cnt_ff;
      v_in      = v_ff;
      best_in   = best_ff;
      root_in   = root_ff;
      top_in    = top_ff;
      ram_addr  = '0;
      ram_we    = 1'b0;
      ram_wdata = v_ff;
      cmp_a     = v_ff;
      cmp_b     = rdata;
      unique case (state_ff)
         E_IDLE: begin
            if (start) begin
               hsel_in = cmd.hsel;
               pop_in  = cmd.pop;
               if (!cmd.pop) begin
                  i_in = cnt_sel[IW-1:0];
                  v_in = start_value;
                  state_in = (cnt_sel == '0) ? E_WR : E_UP_RD;
               end else begin
                  root_in          = top_ff[cmd.hsel];
                  m_in             = cnt_dec;
                  cnt_in[cmd.hsel] = cnt_dec;
                  if (cnt_dec == '0) begin
                     state_in = E_FIN;
                  end else begin
                     // Fetch the last entry; it fills the hole left by the root.
                     ram_addr = cnt_dec[IW-1:0];
                     state_in = E_DN_LAST;
                  end
               end
            end
         end
         E_UP_RD: begin
            ram_addr = parent;
            state_in = E_UP_CMP;
         end
         E_UP_CMP: begin
            cmp_a = v_ff;
            cmp_b = rdata;
            if (above) begin
               ram_we    = 1'b1;
               ram_addr  = i_ff;
               ram_wdata = rdata;
               i_in      = parent;
               state_in  = (parent == '0) ? E_WR : E_UP_RD;
            end else begin
               state_in = E_WR;
            end
         end
         E_DN_LAST: begin
            v_in     = rdata;
            i_in     = '0;
            state_in = E_DN_CHK;
         end
         E_DN_CHK: begin
            if (l_ok) begin
               ram_addr = l_w[IW-1:0];
               state_in = E_DN_L;
            end else begin
               state_in = E_WR;
            end
         end
         E_DN_L: begin
            cmp_a = rdata;
            cmp_b = v_ff;
            if (above) begin
               best_in = rdata;
               bidx_in = l_w[IW-1:0];
            end else begin
               best_in = v_ff;
               bidx_in = i_ff;
            end
            if (r_ok) begin
               ram_addr = r_w[IW-1:0];
               state_in = E_DN_R;
            end else begin
               state_in = E_DN_SEL;
            end
         end
         E_DN_R: begin
            cmp_a = rdata;
            cmp_b = best_ff;
            if (above) begin
               best_in = rdata;
               bidx_in = r_w[IW-1:0];
            end
            state_in = E_DN_SEL;
         end
         E_DN_SEL: begin
            if (bidx_ff == i_ff) begin
               state_in = E_WR;
            end else begin
               ram_we    = 1'b1;
               ram_addr  = i_ff;
               ram_wdata = best_ff;
               if (i_ff == '0) begin
                  top_in[hsel_ff] = best_ff;
               end
               i_in     = bidx_ff;
               state_in = E_DN_CHK;
            end
         end
         E_WR: begin
            ram_we    = 1'b1;
            ram_addr  = i_ff;
            ram_wdata = v_ff;
            if (i_ff == '0) begin
               top_in[hsel_ff] = v_ff;
            end
            if (!pop_ff) begin
               cnt_in[hsel_ff] = cnt_ff[hsel_ff] + CW'(1);
            end
            state_in = E_FIN;
         end
         E_FIN: begin
            state_in = E_IDLE;
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         cnt_ff   <= '{default: '0};
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      hsel_ff <= hsel_in;
      pop_ff  <= pop_in;
      i_ff    <= i_in;
      bidx_ff <= bidx_in;
      m_ff    <= m_in;
      v_ff    <= v_in;
      best_ff <= best_in;
      root_ff <= root_in;
      top_ff  <= top_in;
   end

   assign done        = (state_ff == E_FIN);
   assign pop_value   = root_ff;
   assign top_lower   = top_ff[HEAP_LOWER];
   assign top_upper   = top_ff[HEAP_UPPER];
   assign count_lower = cnt_ff[HEAP_LOWER];
   assign count_upper = cnt_ff[HEAP_UPPER];

endmodule

/* rtl/running_median_two_heaps.sv */
// Running median over two heaps; accepts a sample word, returns twice the median.
// A dropped sample goes straight to the output stage; otherwise one or three heap operations
// run back to back on the heap engine, each heap being a single-port RAM.
// Throughput: one sample at a time; req_tready is high only while no sample is in work, and a
// finished word waits in the output register. Reset (sync, active high) empties both heaps.
`timescale 1ns / 1ps

module running_median_two_heaps
   import rmh_pkg::*;
#(
   parameter int HEAP_DEPTH  = HEAP_DEPTH_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,   // [31:0] sample
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,   // [32:0] median_doubled, [44:33] sample_count
   output logic                     rsp_tuser    // [0] dropped
);

   localparam int CW = $clog2(HEAP_DEPTH + 1);

   typedef enum logic [3:0] {
      T_IDLE  = 4'b0001,
      T_ISSUE = 4'b0010,
      T_WAIT  = 4'b0100,
      T_OUT   = 4'b1000
   } top_state_type;

   top_state_type state_ff, state_in;
   logic [1:0]    step_ff, step_in;
   rmh_op_type    plan_ff [3];
   rmh_op_type    plan_in [3];
   logic signed [SAMPLE_BITS-1:0] x_ff, x_in;
   logic          drop_ff, drop_in;
   logic [MEDIAN_BITS-1:0] med_ff;
   logic [COUNT_BITS-1:0]  cnt_ff;
   logic          rsp_drop_ff;
   logic          rsp_vld_ff;
   logic          load_rsp;

   logic          eng_start;
   rmh_cmd_type   eng_cmd;
   logic signed [SAMPLE_BITS-1:0] eng_value;
   logic          eng_done;
   logic signed [SAMPLE_BITS-1:0] eng_pop;
   logic signed [SAMPLE_BITS-1:0] top_l, top_u;
   logic [CW-1:0] cnt_l, cnt_u;

   logic signed [SAMPLE_BITS-1:0] x_new;
   logic [CW:0]   total;
   logic          full;
   logic          go_low;
   logic signed [33:0] ext_l, ext_u, med_wide;
   rmh_op_type    cur_op;

   rmh_heap_engine #(.HEAP_DEPTH(HEAP_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_engine (
      .clock       (clock),
      .reset       (reset),
      .start       (eng_start),
      .cmd         (eng_cmd),
      .start_value (eng_value),
      .done        (eng_done),
      .pop_value   (eng_pop),
      .top_lower   (top_l),
      .top_upper   (top_u),
      .count_lower (cnt_l),
      .count_upper (cnt_u)
   );

   assign x_new  = $signed(req_tdata[SAMPLE_BITS-1:0]);
   assign total  = {1'b0, cnt_l} + {1'b0, cnt_u};
   assign full   = total >= (CW+1)'(2 * HEAP_DEPTH);
   assign go_low = (cnt_l == '0) || (x_new <= top_l);

   // Twice the median, formed in 34 bits so the sum of two tops never overflows.
   assign ext_l = 34'(top_l);
   assign ext_u = 34'(top_u);
   always_comb begin
      if (cnt_l == '0) begin
         med_wide = '0;
      end else if (cnt_l == cnt_u) begin
         med_wide = ext_l + ext_u;
      end else begin
         med_wide = ext_l <<< 1;
      end
   end

   assign cur_op        = plan_ff[step_ff];
   assign eng_cmd.pop   = cur_op.pop;
   assign eng_cmd.hsel  = cur_op.hsel;
   assign eng_value     = cur_op.use_pop ? eng_pop : x_ff;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      plan_in   = plan_ff;
      x_in      = x_ff;
      drop_in   = drop_ff;
      load_rsp  = 1'b0;
      eng_start = 1'b0;
      unique case (state_ff)
         T_IDLE: begin
            if (req_tvalid) begin
               x_in    = x_new;
               drop_in = full;
               step_in = '0;
               plan_in = '{default: '0};
               if (full) begin
                  state_in = T_OUT;
               end else begin
                  // Root crosses if chosen heap is lower and larger, or upper and not smaller.
                  if (go_low) begin
                     if (cnt_l > cnt_u) begin
                        plan_in[0] = '{1'b1, 1'b1, HEAP_LOWER, 1'b0};
                        plan_in[1] = '{1'b1, 1'b0, HEAP_UPPER, 1'b1};
                        plan_in[2] = '{1'b1, 1'b0, HEAP_LOWER, 1'b0};
                     end else begin
                        plan_in[0] = '{1'b1, 1'b0, HEAP_LOWER, 1'b0};
                     end
                  end else begin
                     plan_in[0] = '{1'b1, 1'b0, HEAP_UPPER, 1'b0};
                     if (cnt_u >= cnt_l) begin
                        plan_in[1] = '{1'b1, 1'b1, HEAP_UPPER, 1'b0};
                        plan_in[2] = '{1'b1, 1'b0, HEAP_LOWER, 1'b1};
                     end
                  end
                  state_in = T_ISSUE;
               end
            end
         end
         T_ISSUE: begin
            if (cur_op.vld) begin
               eng_start = 1'b1;
               state_in  = T_WAIT;
            end else begin
               state_in = T_OUT;
            end
         end
         T_WAIT: begin
            if (eng_done) begin
               if (step_ff == 2'd2) begin
                  state_in = T_OUT;
               end else begin
                  step_in  = step_ff + 2'd1;
                  state_in = T_ISSUE;
               end
            end
         end
         T_OUT: begin
            // The word moves to the output register once that register is free.
            if (!rsp_vld_ff || rsp_tready) begin
               load_rsp = 1'b1;
               state_in = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= T_IDLE;
         step_ff    <= '0;
         plan_ff    <= '{default: '0};
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         plan_ff  <= plan_in;
         if (load_rsp) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      drop_ff <= drop_in;
      if (load_rsp) begin
         med_ff      <= med_wide[MEDIAN_BITS-1:0];
         cnt_ff      <= COUNT_BITS'(total);
         rsp_drop_ff <= drop_ff;
      end
   end

   assign req_tready = (state_ff == T_IDLE);
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS - MEDIAN_BITS - COUNT_BITS){1'b0}}, cnt_ff, med_ff};
   assign rsp_tuser  = rsp_drop_ff;

endmodule
